// ----- hw/rtl/awv_pkg.sv -----
// ============================================================================
// awv_pkg: shared types and constants of the enveloped wavetable voice
// Field widths, configuration register codes, reset values and the
// segment flags that travel down the gain pipeline.
// ============================================================================
package awv_pkg;

    localparam int ENV_W      = 24;
    localparam int PHASE_W    = 32;
    localparam int SCALE_W    = 32;
    localparam int SAMPLE_W   = 16;
    localparam int TIDX_W     = 12;
    localparam int TLEN_W     = 13;
    localparam int GAIN_W     = 17;
    localparam int PROD_W     = PHASE_W + SCALE_W;
    localparam int FRAC_W     = 24;
    localparam int POS_W      = PROD_W - FRAC_W;
    localparam int MULT_W     = SAMPLE_W + GAIN_W + 1;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register stages of the divide and modulo units.
    localparam int DIV_STAGES = 10;

    localparam logic [GAIN_W-1:0]  GAIN_ONE  = 17'h10000;
    localparam logic [GAIN_W-1:0]  GAIN_HALF = 17'h08000;

    localparam logic [ENV_W-1:0]   DECAY_RESET   = 24'd1000;
    localparam logic [ENV_W-1:0]   SUSTAIN_RESET = 24'd2000;
    localparam logic [ENV_W-1:0]   RLS_RESET     = 24'd10000;
    localparam logic [ENV_W-1:0]   FINISH_RESET  = 24'd12000;
    localparam logic [SCALE_W-1:0] STEP_RESET    = 32'd65536;
    localparam int                 TLEN_RESET    = 4096;

    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_RENDER = 1'b1
    } t_cmd;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DECAY   = 3'd0,
        CFG_SUSTAIN = 3'd1,
        CFG_RLS     = 3'd2,
        CFG_FINISH  = 3'd3,
        CFG_STEP    = 3'd4,
        CFG_TLEN    = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [ENV_W-1:0] decay_pt;
        logic [ENV_W-1:0] sustain_pt;
        logic [ENV_W-1:0] rls_pt;
        logic [ENV_W-1:0] finish_pt;
    } t_env_cfg;

    typedef struct packed {
        logic silent;   // past the finish point
        logic full;     // zero-length attack, gain is one
        logic half;     // decay or sustain, quotient rides on one half
    } t_seg;

endpackage

// ----- hw/rtl/awv_req_if.sv -----
// ============================================================================
// awv_req_if: request channel of the voice
// Carries table writes and render requests with a valid/ready handshake.
// ============================================================================
interface awv_req_if;

    logic                               valid;
    logic                               ready;
    logic                               cmd;
    logic [awv_pkg::TIDX_W-1:0]         table_index;
    logic signed [awv_pkg::SAMPLE_W-1:0] table_value;
    logic [awv_pkg::ENV_W-1:0]          envelope_position;
    logic [awv_pkg::PHASE_W-1:0]        phase_position;

    modport source (
        output valid, cmd, table_index, table_value, envelope_position, phase_position,
        input  ready
    );

    modport sink (
        input  valid, cmd, table_index, table_value, envelope_position, phase_position,
        output ready
    );

endinterface

// ----- hw/rtl/awv_rsp_if.sv -----
// ============================================================================
// awv_rsp_if: response channel of the voice
// Carries one enveloped sample per render request.
// ============================================================================
interface awv_rsp_if;

    logic                                valid;
    logic                                ready;
    logic signed [awv_pkg::SAMPLE_W-1:0] sample_out;

    modport source (
        output valid, sample_out,
        input  ready
    );

    modport sink (
        input  valid, sample_out,
        output ready
    );

endinterface

// ----- hw/rtl/adsr_wavetable_voice.sv -----
// ============================================================================
// adsr_wavetable_voice: ADSR-enveloped wavetable voice
// Stores a signed 16-bit wavetable loaded by write requests and renders
// one enveloped sample per render request.
// ============================================================================
//
//  Channel  | Direction | Contents                                      | Transfer
//  ---------+-----------+-----------------------------------------------+-----------------
//  i_req    | in        | cmd, table_index, table_value, envelope, phase | valid && ready
//  o_rsp    | out       | sample_out, one per render request             | valid && ready
//  i_cfg_*  | in        | register index and data                        | i_cfg_we high
//
//  One request per clock while no stall holds the pipeline. A render request
//  passes through the input registers, the divide and modulo pipelines and
//  the memory read, multiply and output registers before its result appears.
//  Writes reach the table in request order with the renders; they give no result.
//  Reset is synchronous and clears the control state and the registers to
//  their defaults; the table holds no defined content until written.
//  A waiting result stalls the pipeline only once another result reaches the
//  last stage; a stall loses and repeats nothing.
//
module adsr_wavetable_voice #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    awv_req_if.sink                            i_req,
    awv_rsp_if.source                          o_rsp,
    input  logic                               i_cfg_we,
    input  logic [awv_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [awv_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int NST = awv_pkg::DIV_STAGES;
    localparam int LW  = $clog2(TABLE_DEPTH + 1);
    localparam int AW  = $clog2(TABLE_DEPTH);
    localparam int PA  = NST + 1;   // table address stage
    localparam int PM  = NST + 2;   // memory read stage
    localparam int PX  = NST + 3;   // product stage
    localparam int NS  = NST + 4;
    localparam int LEN_RST = (TABLE_DEPTH < awv_pkg::TLEN_RESET) ?
                             TABLE_DEPTH : awv_pkg::TLEN_RESET;

    // Configuration
    awv_pkg::t_env_cfg              r_env_cfg;
    logic [awv_pkg::SCALE_W-1:0]    r_step;
    logic [LW-1:0]                  r_len;
    logic [awv_pkg::TLEN_W-1:0]     w_tlen;
    logic [LW-1:0]                  n_len;

    // Pipeline control and carried payload
    logic                           w_en;
    logic [NS-1:0]                  r_vld;
    logic [NS-1:0]                  r_cmd;
    logic [awv_pkg::TIDX_W-1:0]     r_widx [0:PA];
    logic [awv_pkg::SAMPLE_W-1:0]   r_wval [0:PA];
    logic [awv_pkg::ENV_W-1:0]      r_env;
    logic [awv_pkg::PHASE_W-1:0]    r_phase;

    logic [AW-1:0]                  w_raddr;
    logic [AW-1:0]                  w_maddr;
    logic                           w_wr;
    logic [awv_pkg::GAIN_W-1:0]     w_gain;
    logic                           w_silent;
    logic signed [awv_pkg::MULT_W-1:0] w_prod;

    logic                           w_res;
    logic                           r_out_valid;
    logic [awv_pkg::SAMPLE_W-1:0]   r_out_sample;
    logic [awv_pkg::SAMPLE_W-1:0]   n_out_sample;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign w_tlen = i_cfg_data[awv_pkg::TLEN_W-1:0];

    always_comb begin
        if (w_tlen == '0) begin
            n_len = LW'(1);
        end else if (32'(w_tlen) > 32'(TABLE_DEPTH)) begin
            n_len = LW'(TABLE_DEPTH);
        end else begin
            n_len = LW'(w_tlen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env_cfg.decay_pt   <= awv_pkg::DECAY_RESET;
            r_env_cfg.sustain_pt <= awv_pkg::SUSTAIN_RESET;
            r_env_cfg.rls_pt     <= awv_pkg::RLS_RESET;
            r_env_cfg.finish_pt  <= awv_pkg::FINISH_RESET;
            r_step               <= awv_pkg::STEP_RESET;
            r_len                <= LW'(LEN_RST);
        end else if (i_cfg_we) begin
            unique case (awv_pkg::t_cfg_reg'(i_cfg_addr))
                awv_pkg::CFG_DECAY:   r_env_cfg.decay_pt   <= i_cfg_data[awv_pkg::ENV_W-1:0];
                awv_pkg::CFG_SUSTAIN: r_env_cfg.sustain_pt <= i_cfg_data[awv_pkg::ENV_W-1:0];
                awv_pkg::CFG_RLS:     r_env_cfg.rls_pt     <= i_cfg_data[awv_pkg::ENV_W-1:0];
                awv_pkg::CFG_FINISH:  r_env_cfg.finish_pt  <= i_cfg_data[awv_pkg::ENV_W-1:0];
                awv_pkg::CFG_STEP:    r_step               <= i_cfg_data[awv_pkg::SCALE_W-1:0];
                awv_pkg::CFG_TLEN:    r_len                <= n_len;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: everything moves unless a result sits in the last
    // stage and the output register cannot take it.
    // ------------------------------------------------------------------
    assign w_res = r_vld[PX] && (r_cmd[PX] == awv_pkg::CMD_RENDER);
    assign w_en  = !w_res || !r_out_valid || o_rsp.ready;

    assign i_req.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cmd     <= {r_cmd[NS-2:0], i_req.cmd};
            r_widx[0] <= i_req.table_index;
            r_wval[0] <= i_req.table_value;
            r_env     <= i_req.envelope_position;
            r_phase   <= i_req.phase_position;
            for (int k = 1; k <= PA; k++) begin
                r_widx[k] <= r_widx[k-1];
                r_wval[k] <= r_wval[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath units
    // ------------------------------------------------------------------
    awv_index #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_index (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_phase (r_phase),
        .i_step  (r_step),
        .i_len   (r_len),
        .o_addr  (w_raddr)
    );

    awv_gain u_gain (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_env    (r_env),
        .i_cfg    (r_env_cfg),
        .o_gain   (w_gain),
        .o_silent (w_silent)
    );

    // Writes land at the same stage the renders read, so table order holds.
    assign w_wr = r_vld[PA] && (r_cmd[PA] == awv_pkg::CMD_WRITE) &&
                  (32'(r_widx[PA]) < 32'(TABLE_DEPTH));
    assign w_maddr = (r_cmd[PA] == awv_pkg::CMD_WRITE) ? AW'(r_widx[PA]) : w_raddr;

    awv_wave #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_wave (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_wr     (w_wr),
        .i_addr   (w_maddr),
        .i_wdata  (r_wval[PA]),
        .i_gain   (w_gain),
        .i_silent (w_silent),
        .o_prod   (w_prod)
    );

    // ------------------------------------------------------------------
    // Output register. The product is divided by 65536 toward zero: a
    // negative product with a nonzero fraction rounds up by one.
    // ------------------------------------------------------------------
    assign n_out_sample = w_prod[31:16] +
                          {15'b0, w_prod[awv_pkg::MULT_W-1] && (w_prod[15:0] != '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && w_res) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_res) begin
            r_out_sample <= n_out_sample;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.sample_out = r_out_sample;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("pipeline valid bits moved during a stall");

    a_out_from_render: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_vld[PX] && (r_cmd[PX] == awv_pkg::CMD_RENDER)))
        else $error("result raised without a render in the product stage");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len != '0) && (32'(r_len) <= 32'(TABLE_DEPTH)))
        else $error("table length left its legal range");

    a_addr_in_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[PA] && (r_cmd[PA] == awv_pkg::CMD_RENDER)) |-> (LW'(w_raddr) < r_len))
        else $error("render address not below the table length");

endmodule

// ----- hw/rtl/awv_index.sv -----
// ============================================================================
// awv_index: table index pipeline
// Multiplies phase by the step scale, keeps the integer part and reduces it
// modulo the table length with a pipelined restoring remainder.
// ============================================================================
module awv_index #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic [awv_pkg::PHASE_W-1:0]         i_phase,
    input  logic [awv_pkg::SCALE_W-1:0]         i_step,
    input  logic [$clog2(TABLE_DEPTH + 1)-1:0]  i_len,
    output logic [$clog2(TABLE_DEPTH)-1:0]      o_addr
);

    localparam int NST   = awv_pkg::DIV_STAGES;
    localparam int LW    = $clog2(TABLE_DEPTH + 1);
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int POS_W = awv_pkg::POS_W;
    localparam int PER   = (POS_W + NST - 1) / NST;

    logic [awv_pkg::PROD_W-1:0] w_prod;
    logic [POS_W-1:0]           r_pos [0:NST-1];
    logic [LW-1:0]              r_rem [0:NST];

    assign w_prod = awv_pkg::PROD_W'(i_phase) * awv_pkg::PROD_W'(i_step);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos[0] <= w_prod[awv_pkg::PROD_W-1:awv_pkg::FRAC_W];
            r_rem[0] <= '0;
        end
    end

    // Each stage brings down PER dividend bits, most significant first.
    for (genvar s = 1; s <= NST; s++) begin : g_stage
        logic [POS_W-1:0] n_pos;
        logic [LW-1:0]    n_rem;
        logic [LW:0]      trial;

        always_comb begin
            n_pos = r_pos[s-1];
            n_rem = r_rem[s-1];
            trial = '0;
            for (int k = 0; k < PER; k++) begin
                if ((s - 1) * PER + k < POS_W) begin
                    trial = {n_rem, n_pos[POS_W-1]};
                    n_pos = {n_pos[POS_W-2:0], 1'b0};
                    if (trial >= {1'b0, i_len}) begin
                        n_rem = LW'(trial - {1'b0, i_len});
                    end else begin
                        n_rem = trial[LW-1:0];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
            end
        end

        if (s < NST) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pos[s] <= n_pos;
                end
            end
        end
    end

    assign o_addr = AW'(r_rem[NST]);

endmodule

// ----- hw/rtl/awv_gain.sv -----
// ============================================================================
// awv_gain: envelope gain pipeline
// Picks the envelope segment, then divides the segment offset by the
// segment length in a pipelined restoring divider to form a Q1.16 gain.
// ============================================================================
module awv_gain (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [awv_pkg::ENV_W-1:0]     i_env,
    input  awv_pkg::t_env_cfg             i_cfg,
    output logic [awv_pkg::GAIN_W-1:0]    o_gain,
    output logic                          o_silent
);

    localparam int NST = awv_pkg::DIV_STAGES;
    localparam int EW  = awv_pkg::ENV_W;
    localparam int GW  = awv_pkg::GAIN_W;
    localparam int PER = (GW + NST - 1) / NST;

    logic [EW-1:0]   w_num;
    logic [EW-1:0]   w_den;
    logic            w_sh16;
    awv_pkg::t_seg   w_seg;
    logic [EW-1:0]   w_rem0;
    logic [GW-1:0]   w_feed0;

    logic [EW-1:0]   r_rem  [0:NST];
    logic [GW-1:0]   r_q    [0:NST];
    awv_pkg::t_seg   r_seg  [0:NST];
    logic [GW-1:0]   r_feed [0:NST-1];
    logic [EW-1:0]   r_den  [0:NST-1];

    // Segment select. Sustain and silence use a zero offset over a full
    // length so the divider yields zero.
    always_comb begin
        w_num  = '0;
        w_den  = '1;
        w_sh16 = 1'b0;
        w_seg  = '0;
        if (i_env > i_cfg.finish_pt) begin
            w_seg.silent = 1'b1;
        end else if (i_env > i_cfg.rls_pt) begin
            w_num = i_cfg.finish_pt - i_env;
            w_den = i_cfg.finish_pt - i_cfg.rls_pt;
        end else if (i_env > i_cfg.sustain_pt) begin
            w_seg.half = 1'b1;
        end else if (i_env > i_cfg.decay_pt) begin
            w_seg.half = 1'b1;
            w_num = i_cfg.sustain_pt - i_env;
            w_den = i_cfg.sustain_pt - i_cfg.decay_pt;
        end else begin
            w_sh16     = 1'b1;
            w_seg.full = (i_cfg.decay_pt == '0);
            w_num      = i_env;
            w_den      = i_cfg.decay_pt;
        end
    end

    // The offset never exceeds the length, so the upper dividend bits already
    // form a remainder below the divisor and only GW quotient bits remain.
    always_comb begin
        if (w_sh16) begin
            w_rem0  = {1'b0, w_num[EW-1:1]};
            w_feed0 = {w_num[0], {(GW-1){1'b0}}};
        end else begin
            w_rem0  = {2'b00, w_num[EW-1:2]};
            w_feed0 = {w_num[1:0], {(GW-2){1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= w_rem0;
            r_q[0]    <= '0;
            r_seg[0]  <= w_seg;
            r_feed[0] <= w_feed0;
            r_den[0]  <= w_den;
        end
    end

    for (genvar s = 1; s <= NST; s++) begin : g_stage
        logic [EW-1:0] n_rem;
        logic [GW-1:0] n_q;
        logic [GW-1:0] n_feed;
        logic [EW:0]   trial;

        always_comb begin
            n_rem  = r_rem[s-1];
            n_q    = r_q[s-1];
            n_feed = r_feed[s-1];
            trial  = '0;
            for (int k = 0; k < PER; k++) begin
                if ((s - 1) * PER + k < GW) begin
                    trial  = {n_rem, n_feed[GW-1]};
                    n_feed = {n_feed[GW-2:0], 1'b0};
                    if (trial >= {1'b0, r_den[s-1]}) begin
                        n_rem = EW'(trial - {1'b0, r_den[s-1]});
                        n_q   = {n_q[GW-2:0], 1'b1};
                    end else begin
                        n_rem = trial[EW-1:0];
                        n_q   = {n_q[GW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem;
                r_q[s]   <= n_q;
                r_seg[s] <= r_seg[s-1];
            end
        end

        if (s < NST) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_feed[s] <= n_feed;
                    r_den[s]  <= r_den[s-1];
                end
            end
        end
    end

    always_comb begin
        if (r_seg[NST].silent) begin
            o_gain = '0;
        end else if (r_seg[NST].full) begin
            o_gain = awv_pkg::GAIN_ONE;
        end else if (r_seg[NST].half) begin
            o_gain = GW'(awv_pkg::GAIN_HALF + r_q[NST]);
        end else begin
            o_gain = r_q[NST];
        end
    end

    assign o_silent = r_seg[NST].silent;

endmodule

// ----- hw/rtl/awv_wave.sv -----
// ============================================================================
// awv_wave: wavetable memory and gain multiply
// Single-port sample memory with registered read, followed by the
// sample-times-gain product register.
// ============================================================================
module awv_wave #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic                                 i_wr,
    input  logic [$clog2(TABLE_DEPTH)-1:0]       i_addr,
    input  logic [awv_pkg::SAMPLE_W-1:0]         i_wdata,
    input  logic [awv_pkg::GAIN_W-1:0]           i_gain,
    input  logic                                 i_silent,
    output logic signed [awv_pkg::MULT_W-1:0]    o_prod
);

    localparam int SW = awv_pkg::SAMPLE_W;
    localparam int MW = awv_pkg::MULT_W;

    logic [SW-1:0]                r_mem [0:TABLE_DEPTH-1];
    logic [SW-1:0]                r_rdata;
    logic [awv_pkg::GAIN_W-1:0]   r_gain;
    logic                         r_silent;
    logic signed [MW-1:0]         w_mul;
    logic signed [MW-1:0]         n_prod;
    logic signed [MW-1:0]         r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_wr) begin
                r_mem[i_addr] <= i_wdata;
            end
            r_rdata  <= r_mem[i_addr];
            r_gain   <= i_gain;
            r_silent <= i_silent;
        end
    end

    assign w_mul = $signed(r_rdata) * $signed({1'b0, r_gain});

    // A silent render never depends on the table contents.
    always_comb begin
        n_prod = r_silent ? '0 : w_mul;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule
